@@ hdl/kdst_pkg.sv @@
// Shared types and constants for the keyed device state table.
// Depends on nothing; kdst_ctrl, kdst_dp, the top module and the testbench import it.
`timescale 1ns / 1ps

package kdst_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int COUNT_MAX     = 127;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } kdst_cmd_code_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } kdst_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } kdst_state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  vehicle;
    logic [15:0] device;
    logic [7:0]  state;
  } kdst_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic clr_wr;
    logic cnt_inc;
    logic cnt_clr;
    logic commit;
  } kdst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic out_busy;
  } kdst_stat_t;

endpackage

@@ hdl/kdst_if.sv @@
// Valid/ready channel interfaces for the command and result transfers.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface kdst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  vehicle_tag;
  logic [15:0] device_id;
  logic [7:0]  new_state;

  modport source (output valid, command, vehicle_tag, device_id, new_state,
                  input ready);
  modport sink   (input valid, command, vehicle_tag, device_id, new_state,
                  output ready);
endinterface

interface kdst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] entry_count;
  logic [6:0] zero_state_count;

  modport source (output valid, status, entry_count, zero_state_count,
                  input ready);
  modport sink   (input valid, status, entry_count, zero_state_count,
                  output ready);
endinterface

@@ hdl/kdst_ctrl.sv @@
// Sequencer for the table: clearing pass, key scan, commit and result hand-off.
// Depends on kdst_pkg.
`timescale 1ns / 1ps

module kdst_ctrl
  import kdst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kdst_stat_t stat,
  output kdst_cmd_t  cmd
);

  kdst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DRAIN;
        end
      end
      // last read data is compared here
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register can take the new result
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ hdl/kdst_dp.sv @@
// Datapath: entry memory, scan counter, key compare, counts and result register.
// Depends on kdst_pkg.
`timescale 1ns / 1ps

module kdst_dp
  import kdst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  kdst_cmd_t   cmd,
  output kdst_stat_t  stat,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_vehicle_tag,
  input  logic [15:0] in_device_id,
  input  logic [7:0]  in_new_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count,
  output logic [6:0]  out_zero_state_count
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  kdst_entry_t mem [TABLE_DEPTH];
  kdst_entry_t rd_q_r;

  logic [AW-1:0] cnt_r;
  logic          rd_pend_r;
  logic [AW-1:0] rd_idx_r;

  logic [1:0]  cmd_r;
  logic [7:0]  veh_r;
  logic [15:0] dev_r;
  logic [7:0]  st_r;

  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic          hit_zero_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;

  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] zero_r, zero_nxt;

  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [6:0]    entry_cnt_r;
  logic [6:0]    zero_cnt_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  kdst_entry_t   wr_data;
  kdst_status_t  status_nxt;

  function automatic logic [6:0] sat_count(input logic [CW-1:0] c);
    logic [31:0] wide;
    wide = {{(32-CW){1'b0}}, c};
    return (wide > 32'(COUNT_MAX)) ? 7'(COUNT_MAX) : wide[6:0];
  endfunction

  assign stat.cnt_last = (cnt_r == AW'(TABLE_DEPTH - 1));
  assign stat.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r <= in_command;
      veh_r <= in_vehicle_tag;
      dev_r <= in_device_id;
      st_r  <= in_new_state;
    end
  end

  // Commit: decide the outcome from the scan results
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_r;
    wr_data    = '{valid: 1'b1, vehicle: veh_r, device: dev_r, state: st_r};
    held_nxt   = held_r;
    zero_nxt   = zero_r;
    status_nxt = STAT_NOT_FOUND;
    case (kdst_cmd_code_t'(cmd_r))
      CMD_INSERT: begin
        if (hit_r) begin
          status_nxt = STAT_DUPLICATE;
        end else if (!free_r) begin
          status_nxt = STAT_FULL;
        end else begin
          status_nxt = STAT_DONE;
          wr_en      = 1'b1;
          wr_addr    = free_idx_r;
          held_nxt   = held_r + 1'b1;
          zero_nxt   = zero_r + CW'(st_r == 8'd0);
        end
      end
      CMD_UPDATE: begin
        if (hit_r) begin
          status_nxt = STAT_DONE;
          wr_en      = 1'b1;
          zero_nxt   = zero_r - CW'(hit_zero_r) + CW'(st_r == 8'd0);
        end
      end
      CMD_DELETE: begin
        if (hit_r) begin
          status_nxt    = STAT_DONE;
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
          held_nxt      = held_r - 1'b1;
          zero_nxt      = zero_r - CW'(hit_zero_r);
        end
      end
      default: begin
        status_nxt = STAT_NOT_FOUND;
      end
    endcase
  end

  // Single write port: clearing pass or commit; registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[cnt_r] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
    end
    rd_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (rd_pend_r) begin
      if (rd_q_r.valid && rd_q_r.vehicle == veh_r && rd_q_r.device == dev_r) begin
        hit_r <= 1'b1;
      end
      // keep the lowest free slot
      if (!rd_q_r.valid && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      if (rd_q_r.valid && rd_q_r.vehicle == veh_r && rd_q_r.device == dev_r) begin
        hit_idx_r  <= rd_idx_r;
        hit_zero_r <= (rd_q_r.state == 8'd0);
      end
      if (!rd_q_r.valid && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      zero_r <= '0;
    end else if (cmd.commit) begin
      held_r <= held_nxt;
      zero_r <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.commit) begin
      status_r    <= status_nxt;
      entry_cnt_r <= sat_count(held_nxt);
      zero_cnt_r  <= sat_count(zero_nxt);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_entry_count      = entry_cnt_r;
  assign out_zero_state_count = zero_cnt_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(TABLE_DEPTH))
    else $error("held count above table depth");

  a_zero_le_held: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r <= held_r)
    else $error("zero-state count above held count");

  a_commit_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before transfer");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (!hit_r && !free_r))
    else $error("scan flags not cleared at command start");

endmodule

@@ hdl/keyed_device_state_table.sv @@
// Keyed device state table: a table of (vehicle, device) keyed state bytes.
// Each command is accepted in the idle state; the entry memory is then scanned
// through its single registered read port, the last entry is compared in a drain
// state and the commit waits until the output register is free. No new command
// is taken before the commit, and the result then waits in an output register.
// After reset a clearing pass writes each entry once before any command is taken.
// Inserts use the lowest free slot; counts above 127 read as 127.
// Depends on kdst_pkg, kdst_if, kdst_ctrl and kdst_dp.
`timescale 1ns / 1ps

module keyed_device_state_table
  import kdst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  kdst_in_if.sink      in_ch,
  kdst_out_if.source   out_ch
);

  kdst_cmd_t  cmd;
  kdst_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  kdst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kdst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_command           (in_ch.command),
    .in_vehicle_tag       (in_ch.vehicle_tag),
    .in_device_id         (in_ch.device_id),
    .in_new_state         (in_ch.new_state),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_entry_count      (out_ch.entry_count),
    .out_zero_state_count (out_ch.zero_state_count)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for keyed_device_state_table: directed and random commands,
// each checked against hand-typed results or an in-bench model of the keyed table.
// Depends on kdst_pkg, kdst_if and the keyed_device_state_table RTL.
`timescale 1ns / 1ps

module tb_top;
  import kdst_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int RAND_ITEMS = 430;

  typedef struct packed {
    kdst_status_t status;
    logic [6:0]   entry_count;
    logic [6:0]   zero_state_count;
  } table_result_t;

  typedef struct packed {
    kdst_cmd_code_t cmd;
    logic [7:0]     vehicle;
    logic [15:0]    device;
    logic [7:0]     state;
    logic           typed;
    kdst_status_t   status;
    logic [6:0]     entry_count;
    logic [6:0]     zero_state_count;
  } directed_row_t;

  logic clk;
  logic rst_n;

  kdst_in_if  in_ch ();
  kdst_out_if out_ch ();

  keyed_device_state_table #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Table model
  bit          slot_used    [DEPTH];
  logic [7:0]  slot_vehicle [DEPTH];
  logic [15:0] slot_device  [DEPTH];
  logic [7:0]  slot_state   [DEPTH];
  int          n_held;
  int          n_zero;

  table_result_t pending_results [$];

  int mismatch_count;
  int results_seen;
  int items_sent;
  int status_hits [4];
  int peak_entries;
  int idle_pct;
  bit quiet;

  // Hand-checked rows start from an empty table; the rest go through the model.
  directed_row_t directed_rows [20] = '{
    '{CMD_DELETE, 8'h00, 16'h0000, 8'h00, 1'b1, STAT_NOT_FOUND, 7'd0, 7'd0},
    '{CMD_UPDATE, 8'h12, 16'h3456, 8'h05, 1'b1, STAT_NOT_FOUND, 7'd0, 7'd0},
    '{CMD_NONE,   8'hFF, 16'hFFFF, 8'hFF, 1'b1, STAT_NOT_FOUND, 7'd0, 7'd0},
    '{CMD_INSERT, 8'h00, 16'h0000, 8'h00, 1'b1, STAT_DONE,      7'd1, 7'd1},
    '{CMD_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, STAT_DONE,      7'd2, 7'd1},
    '{CMD_INSERT, 8'h00, 16'h0000, 8'h77, 1'b1, STAT_DUPLICATE, 7'd2, 7'd1},
    '{CMD_INSERT, 8'h00, 16'hFFFF, 8'h80, 1'b1, STAT_DONE,      7'd3, 7'd1},
    '{CMD_INSERT, 8'hFF, 16'h0000, 8'h01, 1'b1, STAT_DONE,      7'd4, 7'd1},
    '{CMD_UPDATE, 8'h00, 16'h0000, 8'hFF, 1'b1, STAT_DONE,      7'd4, 7'd0},
    '{CMD_UPDATE, 8'hFF, 16'hFFFF, 8'h00, 1'b1, STAT_DONE,      7'd4, 7'd1},
    '{CMD_UPDATE, 8'hFF, 16'hFFFF, 8'h00, 1'b1, STAT_DONE,      7'd4, 7'd1},
    '{CMD_UPDATE, 8'h00, 16'hFFFF, 8'h00, 1'b1, STAT_DONE,      7'd4, 7'd2},
    '{CMD_DELETE, 8'hFF, 16'hFFFF, 8'h3C, 1'b1, STAT_DONE,      7'd3, 7'd1},
    '{CMD_DELETE, 8'hFF, 16'hFFFF, 8'h00, 1'b1, STAT_NOT_FOUND, 7'd3, 7'd1},
    '{CMD_INSERT, 8'hAA, 16'h5555, 8'h55, 1'b1, STAT_DONE,      7'd4, 7'd1},
    '{CMD_NONE,   8'h00, 16'h0000, 8'h00, 1'b1, STAT_NOT_FOUND, 7'd4, 7'd1},
    '{CMD_DELETE, 8'h00, 16'h0000, 8'h00, 1'b1, STAT_DONE,      7'd3, 7'd1},
    '{CMD_INSERT, 8'h55, 16'hAAAA, 8'hAA, 1'b0, STAT_DONE,      7'd0, 7'd0},
    '{CMD_UPDATE, 8'h55, 16'hAAAA, 8'h00, 1'b0, STAT_DONE,      7'd0, 7'd0},
    '{CMD_DELETE, 8'h55, 16'hAAAA, 8'hFF, 1'b0, STAT_DONE,      7'd0, 7'd0}
  };

  function automatic table_result_t apply_table_command(kdst_cmd_code_t cmd,
                                                        logic [7:0] veh,
                                                        logic [15:0] dev,
                                                        logic [7:0] st);
    table_result_t res;
    int hit;
    int free_slot;
    int s;
    hit = -1;
    free_slot = -1;
    for (s = 0; s < DEPTH; s++) begin
      if (slot_used[s] && slot_vehicle[s] == veh && slot_device[s] == dev && hit < 0)
        hit = s;
      if (!slot_used[s] && free_slot < 0)
        free_slot = s;
    end
    res.status = STAT_NOT_FOUND;
    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_DUPLICATE;
        end else if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          slot_used[free_slot]    = 1'b1;
          slot_vehicle[free_slot] = veh;
          slot_device[free_slot]  = dev;
          slot_state[free_slot]   = st;
          n_held++;
          if (st == 8'h00) n_zero++;
          res.status = STAT_DONE;
        end
      end
      CMD_UPDATE: begin
        if (hit >= 0) begin
          if (slot_state[hit] == 8'h00) n_zero--;
          slot_state[hit] = st;
          if (st == 8'h00) n_zero++;
          res.status = STAT_DONE;
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          if (slot_state[hit] == 8'h00) n_zero--;
          slot_used[hit] = 1'b0;
          n_held--;
          res.status = STAT_DONE;
        end
      end
      default: ;
    endcase
    res.entry_count      = 7'((n_held > COUNT_MAX) ? COUNT_MAX : n_held);
    res.zero_state_count = 7'((n_zero > COUNT_MAX) ? COUNT_MAX : n_zero);
    return res;
  endfunction

  function automatic int pick_held_slot();
    int s;
    s = $urandom_range(0, DEPTH - 1);
    while (!slot_used[s]) s = (s + 1) % DEPTH;
    return s;
  endfunction

  // Entered and left at a falling edge; holds the command until the table takes it.
  task automatic send_command(input kdst_cmd_code_t cmd, input logic [7:0] veh,
                              input logic [15:0] dev, input logic [7:0] st,
                              input logic typed, input table_result_t typed_res);
    table_result_t predicted;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.vehicle_tag <= veh;
    in_ch.device_id   <= dev;
    in_ch.new_state   <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_table_command(cmd, veh, dev, st);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result sink: random stall bursts, one long hold-off to back the table up.
  initial begin
    int stall_pct;
    bit long_hold_done;
    stall_pct = 15;
    long_hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
      end else if (!quiet && rst_n && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      status_hits[out_ch.status]++;
      if (out_ch.entry_count > peak_entries) peak_entries = out_ch.entry_count;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d entries=%0d zeros=%0d", $time,
                 out_ch.status, out_ch.entry_count, out_ch.zero_state_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_ch.status);
          mismatch_count++;
        end
        if (out_ch.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   want.entry_count, out_ch.entry_count);
          mismatch_count++;
        end
        if (out_ch.zero_state_count !== want.zero_state_count) begin
          $display("%0t: zero_state_count expected %0d actual %0d", $time,
                   want.zero_state_count, out_ch.zero_state_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    table_result_t typed_res;
    kdst_cmd_code_t cmd;
    logic [7:0] veh;
    logic [15:0] dev;
    logic [7:0] st;
    bit filling;
    bit use_held;
    int full_stay;
    int r;
    int s;
    int n;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_INSERT;
    in_ch.vehicle_tag = '0;
    in_ch.device_id   = '0;
    in_ch.new_state   = '0;
    quiet             = 1'b0;
    idle_pct          = 30;
    n_held            = 0;
    n_zero            = 0;
    for (s = 0; s < DEPTH; s++) slot_used[s] = 1'b0;
    for (s = 0; s < 4; s++) status_hits[s] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res.status           = directed_rows[i].status;
      typed_res.entry_count      = directed_rows[i].entry_count;
      typed_res.zero_state_count = directed_rows[i].zero_state_count;
      send_command(directed_rows[i].cmd, directed_rows[i].vehicle, directed_rows[i].device,
                   directed_rows[i].state, directed_rows[i].typed, typed_res);
    end

    // Alternate fill and drain phases so the table reaches full and empty repeatedly.
    filling = 1'b1;
    full_stay = 0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end
      if (n >= RAND_ITEMS - 40) quiet = 1'b1;

      r = $urandom_range(0, 99);
      if (r < 4)
        cmd = CMD_NONE;
      else if (filling)
        cmd = (r < 75) ? CMD_INSERT : ((r < 90) ? CMD_UPDATE : CMD_DELETE);
      else
        cmd = (r < 70) ? CMD_DELETE : ((r < 85) ? CMD_UPDATE : CMD_INSERT);

      if (cmd == CMD_INSERT)
        use_held = (n_held == DEPTH) ? ($urandom_range(0, 99) < 30)
                                     : ($urandom_range(0, 99) < (filling ? 10 : 50));
      else
        use_held = $urandom_range(0, 99) < 85;
      if (n_held == 0) use_held = 1'b0;

      if (use_held) begin
        s   = pick_held_slot();
        veh = slot_vehicle[s];
        dev = slot_device[s];
      end else begin
        veh = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        dev = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                   : 16'($urandom_range(0, 65535));
      end
      st = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));

      send_command(cmd, veh, dev, st, 1'b0, typed_res);

      if (filling && n_held == DEPTH) full_stay++;
      if (filling && full_stay >= 20) filling = 1'b0;
      if (!filling && n_held == 0) begin
        filling = 1'b1;
        full_stay = 0;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d commands: %0d done, %0d key not found, %0d duplicate, %0d table full.",
             items_sent, status_hits[STAT_DONE], status_hits[STAT_NOT_FOUND],
             status_hits[STAT_DUPLICATE], status_hits[STAT_FULL]);
    $display("Occupancy peaked at %0d of %0d records; %0d results checked.",
             peak_entries, DEPTH, results_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
